FILE: design/irct_pkg.sv
// Shared types, codes and helper functions of the I/O range claim table.
// Depends on nothing; the controller, datapath, top level and checker use it by scoped names.
package irct_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_CLAIM   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ORDER     = 3'd1;
  localparam logic [2:0] ST_CONFLICT  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic        REG_WATCH_LOW  = 1'b0;
  localparam logic        REG_WATCH_HIGH = 1'b1;
  localparam logic [15:0] WATCH_LOW_RST  = 16'h0CF8;
  localparam logic [15:0] WATCH_HIGH_RST = 16'h0CFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDISSUE,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item, clear the scan state
    logic scan_step;  // one step of the table scan
    logic rd_item;    // read the entry that a read item names
    logic finish;     // update the table and load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;    // the held item is a read
    logic scan_end;   // the last entry has been evaluated this cycle
    logic out_free;   // the output register can take a result
  } dp_sts_t;

  // True when the inclusive spans [a_lo, a_hi] and [b_lo, b_hi] share a port.
  function automatic logic spans_meet(logic [15:0] a_lo, logic [15:0] a_hi,
                                      logic [15:0] b_lo, logic [15:0] b_hi);
    return !((a_hi < b_lo) || (b_hi < a_lo));
  endfunction

endpackage

FILE: design/irct_in_if.sv
// Input channel of the I/O range claim table: valid/ready plus the item fields.
// Depends on nothing.
interface irct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] range_first;
  logic [15:0] range_last;
  logic [15:0] probe_port;
  logic [3:0]  entry_index;

  modport source (output valid, cmd, range_first, range_last, probe_port, entry_index,
                  input ready);
  modport sink (input valid, cmd, range_first, range_last, probe_port, entry_index,
                output ready);
endinterface

FILE: design/irct_out_if.sv
// Result channel of the I/O range claim table: valid/ready plus the result fields.
// Depends on nothing.
interface irct_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic        covered;
  logic        unowned_access;
  logic [15:0] read_first;
  logic [15:0] read_last;
  logic        read_claimed;

  modport source (output valid, status, slot, covered, unowned_access, read_first,
                  read_last, read_claimed, input ready);
  modport sink (input valid, status, slot, covered, unowned_access, read_first,
                read_last, read_claimed, output ready);
endinterface

FILE: design/irct_ctrl.sv
// Controller of the I/O range claim table: sequences accept, scan, read and finish.
// Depends on irct_pkg for the state type and the command and status structs.
module irct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  irct_pkg::dp_sts_t sts,
  output irct_pkg::dp_cmd_t cmd
);

  irct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      irct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = irct_pkg::S_SCAN;
        end
      end
      irct_pkg::S_SCAN: begin
        // A read item skips the scan and fetches its one entry instead.
        if (sts.is_read) begin
          cmd.rd_item = 1'b1;
          state_nxt   = irct_pkg::S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_end) begin
            state_nxt = irct_pkg::S_FINISH;
          end
        end
      end
      irct_pkg::S_RDISSUE: begin
        cmd.rd_item = 1'b1;
        state_nxt   = irct_pkg::S_FINISH;
      end
      irct_pkg::S_FINISH: begin
        // The table is updated only in the cycle the result is stored.
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = irct_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = irct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/irct_dp.sv
// Datapath of the I/O range claim table: entry memory, claimed bits, scan
// evaluation and the output register. Depends on irct_pkg and the channel interfaces.
module irct_dp #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  irct_in_if.sink           in_ch,
  irct_out_if.source        out_ch,
  input  logic [15:0]       watch_low,
  input  logic [15:0]       watch_high,
  input  irct_pkg::dp_cmd_t cmd,
  output irct_pkg::dp_sts_t sts
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Held item.
  logic [1:0]  op_r;
  logic [15:0] first_r;
  logic [15:0] last_r;
  logic [15:0] port_r;
  logic [3:0]  idx_r;

  // Entry memory, {first, last} per slot, with a registered read port.
  logic [31:0] mem [ENTRIES];
  logic [31:0] rdata_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  logic [ENTRIES-1:0] used_r;

  // Scan state.
  logic [CW-1:0] cnt_r;
  logic          pend_vld_r;
  logic [AW-1:0] pend_idx_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic          free_r;
  logic [AW-1:0] free_idx_r;

  // Output register.
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [3:0]  out_slot_r;
  logic        out_covered_r;
  logic        out_unowned_r;
  logic [15:0] out_first_r;
  logic [15:0] out_last_r;
  logic        out_claimed_r;

  logic          scan_end;
  logic          ent_match;
  logic [15:0]   ent_first;
  logic [15:0]   ent_last;
  logic [AW-1:0] item_addr;
  logic          idx_in_range;

  logic [2:0]  res_status;
  logic [3:0]  res_slot;
  logic        res_covered;
  logic        res_unowned;
  logic [15:0] res_first;
  logic [15:0] res_last;
  logic        res_claimed;
  logic        claim_ok;
  logic        release_ok;

  assign scan_end     = (cnt_r == CW'(ENTRIES));
  assign item_addr    = AW'(idx_r);
  assign idx_in_range = ({28'd0, idx_r} < 32'(ENTRIES));
  assign ent_first    = rdata_r[31:16];
  assign ent_last     = rdata_r[15:0];

  assign rd_en   = (cmd.scan_step && !scan_end) || cmd.rd_item;
  assign rd_addr = cmd.rd_item ? item_addr : cnt_r[AW-1:0];

  assign sts.is_read  = (op_r == irct_pkg::CMD_READ);
  assign sts.scan_end = scan_end;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // Match test of the entry whose data has just come out of the memory.
  always_comb begin
    unique case (op_r)
      irct_pkg::CMD_CLAIM:
        ent_match = irct_pkg::spans_meet(first_r, last_r, ent_first, ent_last);
      irct_pkg::CMD_RELEASE:
        ent_match = (ent_first == first_r) && (ent_last == last_r);
      irct_pkg::CMD_CHECK:
        ent_match = irct_pkg::spans_meet(port_r, port_r, ent_first, ent_last);
      default:
        ent_match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[free_idx_r] <= {first_r, last_r};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_ch.cmd;
      first_r <= in_ch.range_first;
      last_r  <= in_ch.range_last;
      port_r  <= in_ch.probe_port;
      idx_r   <= in_ch.entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      pend_idx_r <= '0;
      hit_r      <= 1'b0;
      hit_idx_r  <= '0;
      free_r     <= 1'b0;
      free_idx_r <= '0;
    end else if (cmd.load) begin
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!scan_end) begin
        cnt_r      <= cnt_r + CW'(1);
        pend_vld_r <= 1'b1;
        pend_idx_r <= cnt_r[AW-1:0];
      end else begin
        pend_vld_r <= 1'b0;
      end
      if (pend_vld_r) begin
        if (!hit_r && used_r[pend_idx_r] && ent_match) begin
          hit_r     <= 1'b1;
          hit_idx_r <= pend_idx_r;
        end
        if (!free_r && !used_r[pend_idx_r]) begin
          free_r     <= 1'b1;
          free_idx_r <= pend_idx_r;
        end
      end
    end
  end

  // Result of the held item, valid in the finish state.
  always_comb begin
    res_status  = irct_pkg::ST_OK;
    res_slot    = 4'd0;
    res_covered = 1'b0;
    res_unowned = 1'b0;
    res_first   = 16'd0;
    res_last    = 16'd0;
    res_claimed = 1'b0;
    claim_ok    = 1'b0;
    release_ok  = 1'b0;
    unique case (op_r)
      irct_pkg::CMD_CLAIM: begin
        priority if (first_r > last_r) begin
          res_status = irct_pkg::ST_ORDER;
        end else if (hit_r) begin
          res_status = irct_pkg::ST_CONFLICT;
          res_slot   = 4'(hit_idx_r);
        end else if (!free_r) begin
          res_status = irct_pkg::ST_FULL;
        end else begin
          res_slot = 4'(free_idx_r);
          claim_ok = 1'b1;
        end
      end
      irct_pkg::CMD_RELEASE: begin
        if (hit_r) begin
          res_slot   = 4'(hit_idx_r);
          release_ok = 1'b1;
        end else begin
          res_status = irct_pkg::ST_NOT_FOUND;
        end
      end
      irct_pkg::CMD_CHECK: begin
        if (hit_r) begin
          res_covered = 1'b1;
          res_slot    = 4'(hit_idx_r);
        end else begin
          res_unowned = (port_r >= watch_low) && (port_r <= watch_high);
        end
      end
      default: begin
        if (idx_in_range) begin
          res_slot    = idx_r;
          res_first   = ent_first;
          res_last    = ent_last;
          res_claimed = used_r[item_addr];
        end else begin
          res_status = irct_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign wr_en = cmd.finish && claim_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.finish) begin
      if (claim_ok) begin
        used_r[free_idx_r] <= 1'b1;
      end else if (release_ok) begin
        used_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r  <= res_status;
      out_slot_r    <= res_slot;
      out_covered_r <= res_covered;
      out_unowned_r <= res_unowned;
      out_first_r   <= res_first;
      out_last_r    <= res_last;
      out_claimed_r <= res_claimed;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.covered        = out_covered_r;
  assign out_ch.unowned_access = out_unowned_r;
  assign out_ch.read_first     = out_first_r;
  assign out_ch.read_last      = out_last_r;
  assign out_ch.read_claimed   = out_claimed_r;

endmodule

FILE: design/io_range_claim_table.sv
// Top level of the I/O range claim table: configuration registers on an APB
// port, controller and datapath. Depends on irct_pkg, the channel interfaces,
// irct_ctrl and irct_dp.
//
//   channel  direction  handshake                 carries
//   in_ch    in         valid/ready               cmd, range, probe port, entry index
//   out_ch   out        valid/ready               status, slot, check and read fields
//   cfg_*    in         APB setup/access, pready  watch_low (0x0), watch_high (0x4)
//
// Claim, release and check items scan every entry once through the entry
// memory's single read port; a read item fetches only the entry it names.
// A result waits in the output register while the next item is accepted; a
// stalled output holds the block only at its finish step. Reset is synchronous;
// claimed bits and window registers clear at once, with no clearing pass over
// the entry memory.
module io_range_claim_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  irct_in_if.sink     in_ch,
  irct_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] watch_low_r;
  logic [15:0] watch_high_r;
  logic        cfg_wr;
  logic        cfg_sel;

  irct_pkg::dp_cmd_t dp_cmd;
  irct_pkg::dp_sts_t dp_sts;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_low_r  <= irct_pkg::WATCH_LOW_RST;
      watch_high_r <= irct_pkg::WATCH_HIGH_RST;
    end else if (cfg_wr) begin
      if (cfg_sel == irct_pkg::REG_WATCH_LOW) begin
        watch_low_r <= cfg_pwdata[15:0];
      end else begin
        watch_high_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign cfg_prdata = {16'd0,
                       (cfg_sel == irct_pkg::REG_WATCH_HIGH) ? watch_high_r : watch_low_r};

  irct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  irct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .watch_low  (watch_low_r),
    .watch_high (watch_high_r),
    .cmd        (dp_cmd),
    .sts        (dp_sts)
  );

endmodule

FILE: design/irct_checker.sv
// Port-level checks of the I/O range claim table, bound to the top level.
// Depends on irct_pkg for the status codes.
module irct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [3:0]  out_slot,
  input logic        out_covered,
  input logic        out_unowned_access,
  input logic        out_read_claimed
);

  // A stalled result holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("stalled result changed");

  // One item at a time: the block is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  // A covered port is never flagged as unowned and reports success.
  a_covered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> !out_unowned_access && out_status == irct_pkg::ST_OK)
    else $error("covered result inconsistent");

  // A failed lookup carries no slot and no claimed entry.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == irct_pkg::ST_NOT_FOUND |->
      out_slot == 4'd0 && !out_read_claimed && !out_covered)
    else $error("not-found result carries data");

endmodule

bind io_range_claim_table irct_checker u_irct_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_slot           (out_ch.slot),
  .out_covered        (out_ch.covered),
  .out_unowned_access (out_ch.unowned_access),
  .out_read_claimed   (out_ch.read_claimed)
);
